### hw/rtl/pid_motor_drive_with_deadband_unit_defines.svh
// Assertion macros for the PID motor drive unit.
`ifndef PID_MOTOR_DRIVE_WITH_DEADBAND_UNIT_DEFINES_SVH
`define PID_MOTOR_DRIVE_WITH_DEADBAND_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PMD_CHECK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PMD_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pmd_pkg.sv
// Types and constants shared by the PID motor drive modules.
package pmd_pkg;

	localparam int DATA_W    = 24;
	localparam int ERR_W     = 25;
	localparam int DERR_W    = 26;
	localparam int SUM_W     = 16;
	localparam int WEIGHT_W  = 16;
	localparam int OPA_W     = 25;
	localparam int OPB_W     = 26;
	localparam int PROD_W    = OPA_W + OPB_W;
	localparam int ACC_W     = 52;
	localparam int FRAC_W    = 20;
	localparam int QUOT_W    = ACC_W - FRAC_W;
	localparam int DRIVE_W   = 9;
	localparam int DUTY_W    = 8;
	localparam int STEP_W    = 4;
	localparam int CFG_IDX_W = 3;

	localparam int SUM_LIMIT = 25600;
	localparam int DEADBAND  = 307;
	localparam int DRIVE_MAX = 255;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_I    = 3'd1,
		CFG_GAIN_D    = 3'd2,
		CFG_WEIGHT    = 3'd3,
		CFG_PROTECT   = 3'd4,
		CFG_UPPER     = 3'd5,
		CFG_LOWER     = 3'd6,
		CFG_SWAP      = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEL_A_W,
		SEL_A_WINV,
		SEL_A_GP,
		SEL_A_GD,
		SEL_A_GI
	} mul_a_t;

	typedef enum logic [2:0] {
		SEL_B_PREV,
		SEL_B_RAW,
		SEL_B_ERR,
		SEL_B_DERR,
		SEL_B_SUM
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_Y_RAW,
		ACT_Y_ACC,
		ACT_ERR,
		ACT_STATE,
		ACT_FINISH
	} act_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_NO_SMOOTH,
		JMP_STOP
	} jmp_t;

	typedef struct packed {
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		acc_op_t acc_op;
		act_t    act;
		jmp_t    jmp;
		step_t   target;
	} ctrl_word_t;

	typedef struct packed {
		ctrl_word_t word;
		logic       exec;
		logic       start;
	} seq_ctrl_t;

	typedef struct packed {
		logic no_smooth;
		logic stop;
	} dp_status_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [DATA_W-1:0]    data;
	} cfg_wr_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic [DUTY_W-1:0]         duty;
		logic                      enable_a;
		logic                      enable_b;
	} result_t;

endpackage

### hw/rtl/pmd_sequencer.sv
// Step counter and microcode table that run the PID datapath.
module pmd_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	input  pmd_pkg::dp_status_t  status,
	output pmd_pkg::seq_ctrl_t   ctrl
);

	logic               busy_q;
	pmd_pkg::step_t     step_q;
	pmd_pkg::ctrl_word_t word;
	logic               exec;
	logic               taken;

	// program: step, multiply, accumulate (uses product of previous step), action, jump
	function automatic pmd_pkg::ctrl_word_t ucode(input pmd_pkg::step_t s);
		pmd_pkg::ctrl_word_t w;
		w = '{pmd_pkg::SEL_A_W, pmd_pkg::SEL_B_PREV, pmd_pkg::ACC_HOLD,
			pmd_pkg::ACT_NONE, pmd_pkg::JMP_NONE, pmd_pkg::step_t'(0)};
		case (s)
			4'd0: begin
				w.mul_a  = pmd_pkg::SEL_A_W;
				w.mul_b  = pmd_pkg::SEL_B_PREV;
				w.act    = pmd_pkg::ACT_Y_RAW;
				w.jmp    = pmd_pkg::JMP_NO_SMOOTH;
				w.target = 4'd4;
			end
			4'd1: begin
				w.mul_a  = pmd_pkg::SEL_A_WINV;
				w.mul_b  = pmd_pkg::SEL_B_RAW;
				w.acc_op = pmd_pkg::ACC_LOAD;
			end
			4'd2: w.acc_op = pmd_pkg::ACC_ADD;
			4'd3: w.act = pmd_pkg::ACT_Y_ACC;
			4'd4: w.act = pmd_pkg::ACT_ERR;
			4'd5: begin
				w.mul_a  = pmd_pkg::SEL_A_GP;
				w.mul_b  = pmd_pkg::SEL_B_ERR;
				w.act    = pmd_pkg::ACT_STATE;
				w.jmp    = pmd_pkg::JMP_STOP;
				w.target = 4'd9;
			end
			4'd6: begin
				w.mul_a  = pmd_pkg::SEL_A_GD;
				w.mul_b  = pmd_pkg::SEL_B_DERR;
				w.acc_op = pmd_pkg::ACC_LOAD;
			end
			4'd7: begin
				w.mul_a  = pmd_pkg::SEL_A_GI;
				w.mul_b  = pmd_pkg::SEL_B_SUM;
				w.acc_op = pmd_pkg::ACC_ADD;
			end
			4'd8: w.acc_op = pmd_pkg::ACC_ADD;
			4'd9: w.act = pmd_pkg::ACT_FINISH;
			default: w.act = pmd_pkg::ACT_FINISH;
		endcase
		return w;
	endfunction

	assign word     = ucode(step_q);
	assign in_ready = !busy_q;
	// only the finish step waits, for the output word to drain
	assign exec     = busy_q && ((word.act != pmd_pkg::ACT_FINISH) || out_free);

	always_comb begin
		case (word.jmp)
			pmd_pkg::JMP_NO_SMOOTH: taken = status.no_smooth;
			pmd_pkg::JMP_STOP:      taken = status.stop;
			default:                taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (exec) begin
			if (word.act == pmd_pkg::ACT_FINISH) begin
				busy_q <= 1'b0;
			end else if (taken) begin
				step_q <= word.target;
			end else begin
				step_q <= step_q + pmd_pkg::step_t'(1);
			end
		end
	end

	assign ctrl.word  = word;
	assign ctrl.exec  = exec;
	assign ctrl.start = in_valid && !busy_q;

endmodule

### hw/rtl/pmd_datapath.sv
// Configuration registers, controller state and shared multiply-accumulate datapath.
module pmd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pmd_pkg::cfg_wr_t                    cfg,
	input  pmd_pkg::seq_ctrl_t                  ctrl,
	input  logic signed [pmd_pkg::DATA_W-1:0]   measured,
	input  logic signed [pmd_pkg::DATA_W-1:0]   setpoint,
	output pmd_pkg::dp_status_t                 status,
	output pmd_pkg::result_t                    result
);

	localparam int DW = pmd_pkg::DATA_W;
	localparam int EW = pmd_pkg::ERR_W;
	localparam int DEW = pmd_pkg::DERR_W;
	localparam int SW = pmd_pkg::SUM_W;
	localparam int WW = pmd_pkg::WEIGHT_W;
	localparam int QW = pmd_pkg::QUOT_W;
	localparam int FW = pmd_pkg::FRAC_W;

	localparam logic signed [DEW-1:0] SUM_HI = DEW'(pmd_pkg::SUM_LIMIT);
	localparam logic signed [DEW-1:0] SUM_LO = -SUM_HI;
	localparam logic signed [EW-1:0]  DB_HI  = EW'(pmd_pkg::DEADBAND);
	localparam logic signed [EW-1:0]  DB_LO  = -DB_HI;
	localparam logic signed [QW-1:0]  DRV_HI = QW'(pmd_pkg::DRIVE_MAX);
	localparam logic signed [QW-1:0]  DRV_LO = -DRV_HI;

	// configuration
	logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [WW-1:0]        weight_q;
	logic                 protect_q;
	logic signed [DW-1:0] upper_q, lower_q;
	logic                 swap_q;

	// sample and controller state
	logic signed [DW-1:0]  raw_q, target_q;
	logic signed [DW-1:0]  prev_sample_q;
	logic signed [SW-1:0]  err_sum_q;
	logic signed [EW-1:0]  prev_err_q;
	logic signed [DW-1:0]  y_q;
	logic signed [EW-1:0]  e_q;
	logic signed [DEW-1:0] de_q;
	logic                  stop_q;

	logic signed [pmd_pkg::OPA_W-1:0]  op_a;
	logic signed [pmd_pkg::OPB_W-1:0]  op_b;
	logic signed [pmd_pkg::PROD_W-1:0] prod_q;
	logic signed [pmd_pkg::ACC_W-1:0]  acc_q;
	logic signed [pmd_pkg::ACC_W-1:0]  prod_ext;
	logic [WW:0]                       weight_inv;

	logic                  stop;
	logic signed [DEW-1:0] sum_wide;
	logic signed [SW-1:0]  sum_clamped;

	logic signed [QW-1:0]  quot;
	logic signed [QW-1:0]  quot_trunc;
	logic signed [QW-1:0]  drv_sat;
	logic signed [pmd_pkg::DRIVE_W-1:0] drv;
	logic                  drv_neg, drv_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			weight_q  <= '0;
			protect_q <= 1'b0;
			upper_q   <= '0;
			lower_q   <= '0;
			swap_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (pmd_pkg::cfg_idx_t'(cfg.index))
				pmd_pkg::CFG_GAIN_P:  gain_p_q  <= cfg.data;
				pmd_pkg::CFG_GAIN_I:  gain_i_q  <= cfg.data;
				pmd_pkg::CFG_GAIN_D:  gain_d_q  <= cfg.data;
				pmd_pkg::CFG_WEIGHT:  weight_q  <= cfg.data[WW-1:0];
				pmd_pkg::CFG_PROTECT: protect_q <= cfg.data[0];
				pmd_pkg::CFG_UPPER:   upper_q   <= cfg.data;
				pmd_pkg::CFG_LOWER:   lower_q   <= cfg.data;
				pmd_pkg::CFG_SWAP:    swap_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// 65536 - w; only used when w is nonzero, so it fits 16 bits
	assign weight_inv = (WW+1)'(1 << WW) - {1'b0, weight_q};

	always_comb begin
		case (ctrl.word.mul_a)
			pmd_pkg::SEL_A_W:    op_a = {{(pmd_pkg::OPA_W-WW){1'b0}}, weight_q};
			pmd_pkg::SEL_A_WINV: op_a = {{(pmd_pkg::OPA_W-WW-1){1'b0}}, weight_inv};
			pmd_pkg::SEL_A_GP:   op_a = {gain_p_q[DW-1], gain_p_q};
			pmd_pkg::SEL_A_GD:   op_a = {gain_d_q[DW-1], gain_d_q};
			pmd_pkg::SEL_A_GI:   op_a = {gain_i_q[DW-1], gain_i_q};
			default:             op_a = '0;
		endcase
		case (ctrl.word.mul_b)
			pmd_pkg::SEL_B_PREV: op_b = {{(pmd_pkg::OPB_W-DW){prev_sample_q[DW-1]}}, prev_sample_q};
			pmd_pkg::SEL_B_RAW:  op_b = {{(pmd_pkg::OPB_W-DW){raw_q[DW-1]}}, raw_q};
			pmd_pkg::SEL_B_ERR:  op_b = {{(pmd_pkg::OPB_W-EW){e_q[EW-1]}}, e_q};
			pmd_pkg::SEL_B_DERR: op_b = de_q;
			pmd_pkg::SEL_B_SUM:  op_b = {{(pmd_pkg::OPB_W-SW){err_sum_q[SW-1]}}, err_sum_q};
			default:             op_b = '0;
		endcase
	end

	assign prod_ext = {{(pmd_pkg::ACC_W-pmd_pkg::PROD_W){prod_q[pmd_pkg::PROD_W-1]}}, prod_q};

	// stop: limit window (if protected) or deadband; y_q and e_q hold from the state step on
	assign stop = (protect_q && ((y_q >= upper_q) || (y_q <= lower_q)))
		|| ((e_q <= DB_HI) && (e_q >= DB_LO));

	assign sum_wide = {{(DEW-SW){err_sum_q[SW-1]}}, err_sum_q}
		+ {{(DEW-EW){e_q[EW-1]}}, e_q};

	always_comb begin
		if (sum_wide > SUM_HI) begin
			sum_clamped = SUM_HI[SW-1:0];
		end else if (sum_wide < SUM_LO) begin
			sum_clamped = SUM_LO[SW-1:0];
		end else begin
			sum_clamped = sum_wide[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			raw_q    <= measured;
			target_q <= setpoint;
		end
		if (ctrl.exec) begin
			prod_q <= op_a * op_b;
			case (ctrl.word.acc_op)
				pmd_pkg::ACC_LOAD: acc_q <= prod_ext;
				pmd_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
				default: ;
			endcase
			case (ctrl.word.act)
				pmd_pkg::ACT_Y_RAW: y_q <= raw_q;
				pmd_pkg::ACT_Y_ACC: y_q <= acc_q[DW+WW-1:WW];
				pmd_pkg::ACT_ERR:   e_q <= {y_q[DW-1], y_q} - {target_q[DW-1], target_q};
				pmd_pkg::ACT_STATE: begin
					de_q   <= {e_q[EW-1], e_q} - {prev_err_q[EW-1], prev_err_q};
					stop_q <= stop;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q <= '0;
			err_sum_q     <= '0;
			prev_err_q    <= '0;
		end else if (ctrl.exec) begin
			case (ctrl.word.act)
				pmd_pkg::ACT_Y_ACC: prev_sample_q <= raw_q;
				pmd_pkg::ACT_STATE: begin
					err_sum_q  <= stop ? '0 : sum_clamped;
					prev_err_q <= e_q;
				end
				default: ;
			endcase
		end
	end

	assign status.no_smooth = (weight_q == '0);
	assign status.stop      = stop;

	// divide by 2^20 toward zero, then saturate; zero when the stored stop flag is set
	assign quot       = acc_q[pmd_pkg::ACC_W-1:FW];
	assign quot_trunc = quot + QW'(acc_q[pmd_pkg::ACC_W-1] && (acc_q[FW-1:0] != '0));

	always_comb begin
		if (stop_q) begin
			drv_sat = '0;
		end else if (quot_trunc > DRV_HI) begin
			drv_sat = DRV_HI;
		end else if (quot_trunc < DRV_LO) begin
			drv_sat = DRV_LO;
		end else begin
			drv_sat = quot_trunc;
		end
	end

	assign drv     = drv_sat[pmd_pkg::DRIVE_W-1:0];
	assign drv_neg = drv[pmd_pkg::DRIVE_W-1];
	assign drv_pos = !drv_neg && (drv != '0);

	assign result.drive    = drv;
	assign result.duty     = drv_neg ? pmd_pkg::DUTY_W'(-drv) : drv[pmd_pkg::DUTY_W-1:0];
	assign result.enable_a = swap_q ? drv_pos : drv_neg;
	assign result.enable_b = swap_q ? drv_neg : drv_pos;

endmodule

### hw/rtl/pid_motor_drive_with_deadband_unit.sv
// Top level of the PID motor drive unit with deadband and integral clamp.
// Each sample word runs a short microprogram on one shared 25x26 multiplier:
// 4 to 10 program steps (10 with smoothing on, 7 without; a stopped sample
// skips the steps that sum the three gain products). The result sits in an
// output register; the next sample is taken while it waits, and only the
// final step stalls if that register is still full. Configuration writes
// are taken at once.
`include "pid_motor_drive_with_deadband_unit_defines.svh"

module pid_motor_drive_with_deadband_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pmd_pkg::DATA_W-1:0]      measured,
	input  logic signed [pmd_pkg::DATA_W-1:0]      setpoint,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pmd_pkg::DRIVE_W-1:0]     drive,
	output logic [pmd_pkg::DUTY_W-1:0]             duty,
	output logic                                   enable_a,
	output logic                                   enable_b,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pmd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pmd_pkg::DATA_W-1:0]             cfg_data
);

	pmd_pkg::seq_ctrl_t  ctrl;
	pmd_pkg::dp_status_t status;
	pmd_pkg::result_t    result;
	pmd_pkg::cfg_wr_t    cfg;
	pmd_pkg::result_t    res_q;
	logic                out_valid_q;
	logic                out_free;
	logic                finish;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign out_free = !out_valid_q || out_ready;
	assign finish   = ctrl.exec && (ctrl.word.act == pmd_pkg::ACT_FINISH);

	pmd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.status   (status),
		.ctrl     (ctrl)
	);

	pmd_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ctrl     (ctrl),
		.measured (measured),
		.setpoint (setpoint),
		.status   (status),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = res_q.drive;
	assign duty      = res_q.duty;
	assign enable_a  = res_q.enable_a;
	assign enable_b  = res_q.enable_b;

	`PMD_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`PMD_CHECK_NEXT(a_result_after_finish, finish, out_valid, "finish lost its result word")
	`PMD_CHECK_SAME(a_zero_drive_idle, out_valid && (drive == '0), (duty == '0) && !enable_a && !enable_b, "zero drive not idle")
	`PMD_CHECK_SAME(a_one_direction, out_valid && (drive != '0), (enable_a != enable_b) && (duty != '0), "direction enables wrong")

endmodule

### sim/pid_motor_drive_with_deadband_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PID motor drive unit: directed table, then random phases.
module pid_motor_drive_with_deadband_unit_tb;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 195;
	localparam int HOLD_CYCLES = 300;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		pmd_pkg::cfg_idx_t  idx;
		logic [23:0]        m;
		logic [23:0]        s;
		bit                 typed;
		pmd_pkg::result_t   res;
	} stim_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic signed [pmd_pkg::DATA_W-1:0]  measured;
	logic signed [pmd_pkg::DATA_W-1:0]  setpoint;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [pmd_pkg::DRIVE_W-1:0] drive;
	logic [pmd_pkg::DUTY_W-1:0]         duty;
	logic                               enable_a;
	logic                               enable_b;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [pmd_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [pmd_pkg::DATA_W-1:0]         cfg_data;

	// controller copy: registers and state, all zero after reset
	longint      kp, ki, kd, upper_q8, lower_q8;
	int unsigned smooth_w;
	bit          protect_en, swap_dir;
	longint      prev_raw, err_sum, prev_err;

	pmd_pkg::result_t drive_expect_q[$];
	stim_row_t        stim_rows[$];
	int               fails = 0;
	bit               quiet;
	bit               hold_req;
	bit               hold_done = 1'b0;

	pid_motor_drive_with_deadband_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.measured  (measured),
		.setpoint  (setpoint),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.duty      (duty),
		.enable_a  (enable_a),
		.enable_b  (enable_b),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pmd_pkg::result_t pid_drive_step(input logic signed [23:0] m,
			input logic signed [23:0] s);
		longint           y, e, de, sum, acc, drv, mag;
		bit               stop;
		pmd_pkg::result_t r;
		if (smooth_w != 0) begin
			acc = longint'(smooth_w) * prev_raw + longint'(65536 - smooth_w) * longint'(m);
			y = acc >>> 16;
			prev_raw = longint'(m);
		end else begin
			y = longint'(m);
		end
		e = y - longint'(s);
		sum = err_sum + e;
		if (sum > pmd_pkg::SUM_LIMIT) sum = pmd_pkg::SUM_LIMIT;
		if (sum < -pmd_pkg::SUM_LIMIT) sum = -pmd_pkg::SUM_LIMIT;
		err_sum = sum;
		de = e - prev_err;
		prev_err = e;
		stop = protect_en && (y >= upper_q8 || y <= lower_q8);
		if (e <= pmd_pkg::DEADBAND && e >= -pmd_pkg::DEADBAND) stop = 1'b1;
		if (stop) begin
			err_sum = 0;
			drv = 0;
		end else begin
			acc = kp * e + kd * de + ki * err_sum;
			drv = acc / (longint'(1) << pmd_pkg::FRAC_W);
			if (drv > pmd_pkg::DRIVE_MAX) drv = pmd_pkg::DRIVE_MAX;
			if (drv < -pmd_pkg::DRIVE_MAX) drv = -pmd_pkg::DRIVE_MAX;
		end
		mag = (drv < 0) ? -drv : drv;
		r.drive = drv[8:0];
		r.duty = mag[7:0];
		r.enable_a = swap_dir ? (drv > 0) : (drv < 0);
		r.enable_b = swap_dir ? (drv < 0) : (drv > 0);
		return r;
	endfunction

	function automatic void row_item(input logic [23:0] m, input logic [23:0] s,
			input bit typed, input logic signed [8:0] drv = 0, input logic [7:0] dt = 0,
			input bit ea = 0, input bit eb = 0);
		stim_row_t r;
		r.kind = ROW_ITEM;
		r.idx = pmd_pkg::CFG_GAIN_P;
		r.m = m;
		r.s = s;
		r.typed = typed;
		r.res.drive = drv;
		r.res.duty = dt;
		r.res.enable_a = ea;
		r.res.enable_b = eb;
		stim_rows.push_back(r);
	endfunction

	function automatic void row_cfg(input pmd_pkg::cfg_idx_t idx, input logic [23:0] val);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.m = '0;
		r.s = val;
		r.typed = 1'b0;
		r.res = '0;
		stim_rows.push_back(r);
	endfunction

	function automatic logic [23:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	// block is idle once the last word has come out
	task automatic write_reg(input pmd_pkg::cfg_idx_t idx, input logic [23:0] val);
		in_valid = 1'b0;
		while (drive_expect_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pmd_pkg::CFG_GAIN_P:  kp = longint'($signed(val));
			pmd_pkg::CFG_GAIN_I:  ki = longint'($signed(val));
			pmd_pkg::CFG_GAIN_D:  kd = longint'($signed(val));
			pmd_pkg::CFG_WEIGHT:  smooth_w = 32'(val[15:0]);
			pmd_pkg::CFG_PROTECT: protect_en = val[0];
			pmd_pkg::CFG_UPPER:   upper_q8 = longint'($signed(val));
			pmd_pkg::CFG_LOWER:   lower_q8 = longint'($signed(val));
			pmd_pkg::CFG_SWAP:    swap_dir = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// caller is at a falling edge; valid stays up until the caller idles or sends again
	task automatic send_item(input logic [23:0] m, input logic [23:0] s, input bit typed,
			input pmd_pkg::result_t fixed_res);
		pmd_pkg::result_t predicted;
		in_valid = 1'b1;
		measured = m;
		setpoint = s;
		do @(posedge clk); while (!in_ready);
		predicted = pid_drive_step(m, s);
		drive_expect_q.push_back(typed ? fixed_res : predicted);
		@(negedge clk);
	endtask

	task automatic idle_in(input int n);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		logic signed [23:0] g_p, g_i, g_d, lim_hi, lim_lo, sp_v, m_v, s_v;
		logic [15:0]        w_v;
		int                 off, pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		measured = '0;
		setpoint = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;

		// gains are zero after reset: drive stays zero whatever the error
		row_item(24'h7FFFFF, 24'h800000, 1);
		row_item(24'h800000, 24'h7FFFFF, 1);
		row_item(24'h000000, 24'h000000, 1);
		// unit proportional gain: drive is the error truncated to whole units
		row_cfg(pmd_pkg::CFG_GAIN_P, 24'd4096);
		row_item(24'd25600, 24'd0, 1, 9'sd100, 8'd100, 1'b0, 1'b1);
		row_item(24'd308, 24'd0, 1, 9'sd1, 8'd1, 1'b0, 1'b1);
		row_item(24'd307, 24'd0, 1);
		row_item(-24'sd307, 24'd0, 1);
		row_item(-24'sd308, 24'd0, 1, -9'sd1, 8'd1, 1'b1, 1'b0);
		row_item(24'h7FFFFF, 24'h800000, 1, 9'sd255, 8'd255, 1'b0, 1'b1);
		row_item(24'h800000, 24'h7FFFFF, 1, -9'sd255, 8'd255, 1'b1, 1'b0);
		row_cfg(pmd_pkg::CFG_SWAP, 24'd1);
		row_item(24'd25600, 24'd0, 1, 9'sd100, 8'd100, 1'b1, 1'b0);
		row_item(-24'sd25600, 24'd0, 1, -9'sd100, 8'd100, 1'b0, 1'b1);
		// limit window of +/-50.0
		row_cfg(pmd_pkg::CFG_UPPER, 24'd12800);
		row_cfg(pmd_pkg::CFG_LOWER, -24'sd12800);
		row_cfg(pmd_pkg::CFG_PROTECT, 24'd1);
		row_item(24'd12800, 24'd0, 1);
		row_item(-24'sd12800, 24'd0, 1);
		row_item(24'd12799, 24'd0, 1, 9'sd49, 8'd49, 1'b1, 1'b0);
		row_item(24'd20000, 24'd0, 1);
		// full PID with smoothing: sum clamp, deadband clear, weight extreme
		row_cfg(pmd_pkg::CFG_PROTECT, 24'd0);
		row_cfg(pmd_pkg::CFG_GAIN_I, 24'd4096);
		row_cfg(pmd_pkg::CFG_GAIN_D, 24'd4096);
		row_cfg(pmd_pkg::CFG_WEIGHT, 24'd32768);
		row_item(24'd25600, 24'd0, 0);
		row_item(24'd25600, 24'd0, 0);
		row_item(24'd10000, 24'd0, 0);
		row_item(24'd300, 24'd0, 0);
		row_item(-24'sd25600, 24'd0, 0);
		row_item(-24'sd25600, 24'd0, 0);
		row_cfg(pmd_pkg::CFG_WEIGHT, 24'd65535);
		row_item(24'h7FFFFF, 24'h800000, 0);
		row_item(24'h800000, 24'h7FFFFF, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_reg(stim_rows[i].idx, stim_rows[i].s);
			else
				send_item(stim_rows[i].m, stim_rows[i].s, stim_rows[i].typed, stim_rows[i].res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					g_p = 24'h7FFFFF;
					g_i = 24'h7FFFFF;
					g_d = 24'h7FFFFF;
				end
				1: begin
					g_p = 24'h800000;
					g_i = 24'h800000;
					g_d = 24'h800000;
				end
				default: begin
					g_p = 24'($urandom);
					g_i = 24'($urandom);
					g_d = 24'($urandom);
					g_p = g_p >>> $urandom_range(4, 20);
					g_i = g_i >>> $urandom_range(4, 20);
					g_d = g_d >>> $urandom_range(4, 20);
				end
			endcase
			if (ph == 2)
				w_v = 16'hFFFF;
			else if (ph == 3 || $urandom_range(0, 3) == 0)
				w_v = 16'h0000;
			else
				w_v = 16'($urandom_range(1, 65535));
			case (ph % 3)
				0: begin
					lim_hi = 24'h7FFFFF;
					lim_lo = 24'h800000;
				end
				1: begin
					lim_hi = 24'($urandom_range(256, 1 << 21));
					lim_lo = 24'(-int'($urandom_range(256, 1 << 21)));
				end
				default: begin
					lim_hi = 24'($urandom);
					lim_lo = 24'($urandom);
				end
			endcase
			quiet = (ph == PHASES - 1);
			write_reg(pmd_pkg::CFG_GAIN_P, g_p);
			write_reg(pmd_pkg::CFG_GAIN_I, g_i);
			write_reg(pmd_pkg::CFG_GAIN_D, g_d);
			write_reg(pmd_pkg::CFG_WEIGHT, {8'h00, w_v});
			write_reg(pmd_pkg::CFG_PROTECT, (ph == 1) ? 24'd1 : 24'($urandom_range(0, 1)));
			write_reg(pmd_pkg::CFG_UPPER, lim_hi);
			write_reg(pmd_pkg::CFG_LOWER, lim_lo);
			write_reg(pmd_pkg::CFG_SWAP, 24'(ph % 2));
			sp_v = 24'($urandom);
			sp_v = sp_v >>> 1;
			// first phase: receiver holds off while words keep coming
			if (ph == 0) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 7) == 0)
					idle_in($urandom_range(1, 17));
				if ($urandom_range(0, 15) == 0) begin
					sp_v = 24'($urandom);
					sp_v = sp_v >>> 1;
				end
				pick = $urandom_range(0, 9);
				case (pick)
					0, 1, 2, 3: off = int'($urandom_range(0, 8000)) - 4000;
					4, 5: off = int'($urandom_range(305, 310)) * ($urandom_range(0, 1) ? 1 : -1);
					6, 7: off = int'($urandom_range(0, 1 << 19)) - (1 << 18);
					default: off = 0;
				endcase
				m_v = 24'(int'(sp_v) + off);
				s_v = sp_v;
				if (pick == 8) begin
					m_v = 24'($urandom);
					s_v = 24'($urandom);
				end else if (pick == 9) begin
					m_v = corner_value();
					s_v = corner_value();
				end
				send_item(m_v, s_v, 1'b0, '0);
			end
		end

		in_valid = 1'b0;
		while (drive_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				out_ready = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pmd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_expect_q.size() == 0) begin
				$display("%0t ns: output word with none expected, actual drive %0d",
					$time, drive);
				fails++;
			end else begin
				want = drive_expect_q.pop_front();
				check_field("drive", want.drive, drive);
				check_field("duty", want.duty, duty);
				check_field("enable_a", want.enable_a, enable_a);
				check_field("enable_b", want.enable_b, enable_b);
			end
		end
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
